// ----- hw/rtl/poly1305_mac_defines.svh -----
// Assertion macros shared by the poly1305_mac RTL
`ifndef POLY1305_MAC_DEFINES_SVH
`define POLY1305_MAC_DEFINES_SVH

// Property checked on every clock edge outside reset
`define P1305_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset
`define P1305_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/p1305_pkg.sv -----
package p1305_pkg;

  localparam int unsigned NumLimbs = 5;

  typedef logic [26:0] limb_t;    // stored accumulator limb
  typedef logic [27:0] hsum_t;    // accumulator limb plus message limb
  typedef logic [25:0] rlimb_t;   // clamped key limb
  typedef logic [28:0] slimb_t;   // clamped key limb times five

  localparam logic [25:0] Clamp0 = 26'h3ff_ffff;
  localparam logic [25:0] Clamp1 = 26'h3ff_ff03;
  localparam logic [25:0] Clamp2 = 26'h3ff_c0ff;
  localparam logic [25:0] Clamp3 = 26'h3f0_3fff;
  localparam logic [25:0] Clamp4 = 26'h00f_ffff;

  localparam logic [31:0] LimbMask = 32'h03ff_ffff;
  localparam logic [31:0] Limb4Top = 32'h0400_0000;

  typedef enum logic [1:0] {
    CFG_R_LOW  = 2'd0,
    CFG_R_HIGH = 2'd1,
    CFG_S_LOW  = 2'd2,
    CFG_S_HIGH = 2'd3
  } p1305_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4
  } p1305_state_e;

endpackage

// ----- hw/rtl/poly1305_mac.sv -----
// Poly1305 MAC: one 16-byte block per input beat, 26-bit limbs, one shared 28x29 multiplier.
// A non-empty block runs 25 limb products on the multiplier (ST_MUL), then a carry fold
// (ST_FIX). A last block then passes ST_FIN1 to ST_FIN4, which waits for a free output;
// an empty last block goes straight to ST_FIN1. A new block is taken only in ST_IDLE, once
// the last is through. Reset clears keys, accumulator and control at once; no clearing pass.
`include "poly1305_mac_defines.svh"

module poly1305_mac import p1305_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] tag_low_o,
  output logic [63:0] tag_high_o
);

  p1305_state_e state_q, state_d;

  logic [63:0] r_low_q, r_high_q, s_low_q, s_high_q;
  limb_t       h_q  [NumLimbs];
  hsum_t       hs_q [NumLimbs];
  rlimb_t      rl_q [NumLimbs];
  slimb_t      sl_q [NumLimbs];
  logic [2:0]  k_q, j_q;
  logic [63:0] acc_q;
  logic [31:0] cfin_q;
  logic        last_q;
  logic [31:0] f_q [NumLimbs];
  logic [63:0] hi_q;
  logic        cy_q;
  logic        out_valid_q;
  logic [63:0] tag_low_q, tag_high_q;

  logic        in_acc;
  logic        fin_go;
  logic        acc_zero;
  logic        blk_go;

  // ---------------------------------------------------------------- key limbs
  logic [127:0] key;
  rlimb_t       rc  [NumLimbs];
  slimb_t       rc5 [NumLimbs];

  assign key   = {r_high_q, r_low_q};
  assign rc[0] = key[25:0]   & Clamp0;
  assign rc[1] = key[51:26]  & Clamp1;
  assign rc[2] = key[77:52]  & Clamp2;
  assign rc[3] = key[103:78] & Clamp3;
  assign rc[4] = {2'b00, key[127:104]} & Clamp4;

  always_comb begin
    for (int i = 0; i < NumLimbs; i++) begin
      rc5[i] = {3'b000, rc[i]} + {1'b0, rc[i], 2'b00};
    end
  end

  // ---------------------------------------------------------------- message pad
  logic [127:0] msg, mpad;
  logic         full;
  logic [25:0]  ml [NumLimbs];
  hsum_t        hs_d [NumLimbs];

  assign msg  = {block_high_i, block_low_i};
  assign full = byte_count_i[4];

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      if (full || (5'(b) < byte_count_i)) begin
        mpad[8*b +: 8] = msg[8*b +: 8];
      end else if (5'(b) == byte_count_i) begin
        mpad[8*b +: 8] = 8'h01;
      end else begin
        mpad[8*b +: 8] = 8'h00;
      end
    end
  end

  assign ml[0] = mpad[25:0];
  assign ml[1] = mpad[51:26];
  assign ml[2] = mpad[77:52];
  assign ml[3] = mpad[103:78];
  assign ml[4] = {1'b0, full, mpad[127:104]};

  always_comb begin
    for (int i = 0; i < NumLimbs; i++) begin
      hs_d[i] = {1'b0, h_q[i]} + {2'b00, ml[i]};
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  // Output limb k, term j: h_j * r_(k-j), wrapping to 5*r_(k-j+5) above the diagonal.
  logic [2:0]  idx;
  logic [28:0] opnd;
  logic [56:0] prod;
  logic [63:0] sum;

  always_comb begin
    if (k_q >= j_q) begin
      idx  = k_q - j_q;
      opnd = {3'b000, rl_q[idx]};
    end else begin
      idx  = k_q + 3'd5 - j_q;
      opnd = sl_q[idx];
    end
  end

  assign prod = 57'(hs_q[j_q]) * 57'(opnd);
  assign sum  = acc_q + 64'(prod);

  // ---------------------------------------------------------------- carry fold
  logic [31:0] t0;
  limb_t       h1_fix;

  assign t0     = 32'(h_q[0]) + cfin_q + (cfin_q << 2);
  assign h1_fix = 27'(32'(h_q[1]) + (t0 >> 26));

  // ---------------------------------------------------------------- finalization
  logic [31:0] u [NumLimbs];
  logic [31:0] g [NumLimbs];
  logic [31:0] cc, gc;
  logic [63:0] lo_w, hi_w;
  logic [64:0] lo_sum;

  always_comb begin
    for (int i = 0; i < NumLimbs; i++) begin
      u[i] = 32'(h_q[i]);
    end
    cc = u[1] >> 26; u[1] = u[1] & LimbMask; u[2] = u[2] + cc;
    cc = u[2] >> 26; u[2] = u[2] & LimbMask; u[3] = u[3] + cc;
    cc = u[3] >> 26; u[3] = u[3] & LimbMask; u[4] = u[4] + cc;
    cc = u[4] >> 26; u[4] = u[4] & LimbMask; u[0] = u[0] + cc + (cc << 2);
    cc = u[0] >> 26; u[0] = u[0] & LimbMask; u[1] = u[1] + cc;
  end

  // Try h + 5 - 2^130; keep it when it does not go negative.
  always_comb begin
    g[0] = f_q[0] + 32'd5;
    gc = g[0] >> 26; g[0] = g[0] & LimbMask;
    g[1] = f_q[1] + gc; gc = g[1] >> 26; g[1] = g[1] & LimbMask;
    g[2] = f_q[2] + gc; gc = g[2] >> 26; g[2] = g[2] & LimbMask;
    g[3] = f_q[3] + gc; gc = g[3] >> 26; g[3] = g[3] & LimbMask;
    g[4] = f_q[4] + gc - Limb4Top;
  end

  assign lo_w = {32'd0, f_q[0]} | ({32'd0, f_q[1]} << 26) | ({32'd0, f_q[2]} << 52);
  assign hi_w = ({32'd0, f_q[2]} >> 12) | ({32'd0, f_q[3]} << 14) | ({32'd0, f_q[4]} << 40);
  assign lo_sum = {1'b0, lo_w} + {1'b0, s_low_q};

  // ---------------------------------------------------------------- sequencer
  assign in_acc = in_valid_i && in_ready_o;
  assign fin_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_count_i != 5'd0) begin
            state_d = ST_MUL;
          end else if (last_i) begin
            state_d = ST_FIN1;
          end
        end
      end
      ST_MUL: begin
        if (k_q == 3'd4 && j_q == 3'd4) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX:  state_d = last_q ? ST_FIN1 : ST_IDLE;
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: state_d = ST_FIN3;
      ST_FIN3: state_d = ST_FIN4;
      ST_FIN4: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_low_q     <= '0;
      r_high_q    <= '0;
      s_low_q     <= '0;
      s_high_q    <= '0;
      k_q         <= '0;
      j_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumLimbs; i++) begin
        h_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (p1305_cfg_e'(cfg_idx_i))
          CFG_R_LOW:  r_low_q  <= cfg_data_i;
          CFG_R_HIGH: r_high_q <= cfg_data_i;
          CFG_S_LOW:  s_low_q  <= cfg_data_i;
          CFG_S_HIGH: s_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        last_q <= last_i;
        k_q    <= '0;
        j_q    <= '0;
      end
      if (state_q == ST_MUL) begin
        if (j_q == 3'd4) begin
          h_q[k_q] <= {1'b0, sum[25:0]};
          j_q      <= '0;
          k_q      <= k_q + 3'd1;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      if (state_q == ST_FIX) begin
        h_q[0] <= {1'b0, t0[25:0]};
        h_q[1] <= h1_fix;
      end
      // drop the accumulator once its value is in the finalization registers
      if (state_q == ST_FIN1) begin
        for (int i = 0; i < NumLimbs; i++) begin
          h_q[i] <= '0;
        end
      end
      if (state_q == ST_FIN4 && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q <= '0;
      for (int i = 0; i < NumLimbs; i++) begin
        hs_q[i] <= hs_d[i];
        rl_q[i] <= rc[i];
        sl_q[i] <= rc5[i];
      end
    end
    if (state_q == ST_MUL) begin
      if (j_q == 3'd4) begin
        acc_q <= sum >> 26;
        if (k_q == 3'd4) begin
          cfin_q <= 32'(sum >> 26);
        end
      end else begin
        acc_q <= sum;
      end
    end
    if (state_q == ST_FIN1) begin
      for (int i = 0; i < NumLimbs; i++) begin
        f_q[i] <= u[i];
      end
    end
    if (state_q == ST_FIN2 && !g[4][31]) begin
      for (int i = 0; i < NumLimbs; i++) begin
        f_q[i] <= g[i];
      end
    end
    if (state_q == ST_FIN3) begin
      acc_q <= lo_sum[63:0];
      cy_q  <= lo_sum[64];
      hi_q  <= hi_w;
    end
    if (state_q == ST_FIN4 && fin_go) begin
      tag_low_q  <= acc_q;
      tag_high_q <= hi_q + s_high_q + 64'(cy_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_low_o   = tag_low_q;
  assign tag_high_o  = tag_high_q;

  assign acc_zero = (h_q[0] == '0) && (h_q[1] == '0) && (h_q[2] == '0) &&
                    (h_q[3] == '0) && (h_q[4] == '0);
  assign blk_go   = in_acc && (byte_count_i != 5'd0);

  `P1305_ASSERT(a_tag_from_fin, $rose(out_valid_o) |-> $past(state_q) == ST_FIN4, "stray tag")
  `P1305_NEVER(a_mul_range, state_q == ST_MUL && (k_q > 3'd4 || j_q > 3'd4), "counter range")
  `P1305_ASSERT(a_acc_cleared, state_q == ST_FIN1 |=> acc_zero, "accumulator not cleared")
  `P1305_ASSERT(a_block_starts, blk_go |=> state_q == ST_MUL && k_q == '0 && j_q == '0, "no start")

endmodule
